[rtl/core/lpd_pkg.sv]
// Package for the length-prefixed deframer: result kinds, result record, header constants.
// No dependencies; imported by every module of the block.
package lpd_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 23;
  localparam int unsigned MAX_LEN_BITS       = 23;
  localparam logic [MAX_LEN_BITS-1:0] LIMIT_RESET = 23'h7fffff;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned TYPE_BYTES   = 2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] msg_type;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
  } result_t;

endpackage

[rtl/core/length_prefixed_deframer.sv]
// Top level of the length-prefixed deframer: input register, parser, result register.
// Depends on lpd_pkg, lpd_parse and lpd_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte) carries the raw stream, one byte per item.
//   Each message is a 6-byte header (big-endian 16-bit type, big-endian 32-bit length)
//   followed by that many payload bytes.
//   Output channel (out_valid/out_ready) carries one item per payload byte with its
//   msg_type and first/last marks, one empty item (kind 1) for a zero-length message,
//   or one error item (kind 2) for a length above max_length or above 2^COUNT_BITS-1.
//   After an error every further input byte is taken and dropped until reset.
//   cfg_we/cfg_wdata write max_length; write it only while idle.
// Timing:
//   An accepted byte is loaded into the input register; the parser's result for it is then
//   moved into the result register, from which the sink takes it. Throughput is one byte per
//   cycle while the sink keeps out_ready high, limited only by the single result register;
//   header bytes give no item.
// Reset (rst, synchronous): clears the parser state, sets max_length to 0x7fffff,
//   empties both registers.
// Stall: while out_ready is low with a result waiting, the input register still fills;
//   once both are full in_ready drops until the sink takes the result.
module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              kind,
  output logic [15:0]             msg_type,
  output logic [7:0]              payload_byte,
  output logic                    first_byte,
  output logic                    last_byte,
  input  logic                    cfg_we,
  input  logic [MAX_LEN_BITS-1:0] cfg_wdata
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       step;
  logic       can_load;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // advance the held byte whenever the result register can take what it yields
  assign step     = in_full && can_load;
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte <= data_byte;
    end
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  lpd_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .step_byte (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold the result until the sink takes it
  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign msg_type     = out_res.msg_type;
  assign payload_byte = out_res.payload_byte;
  assign first_byte   = out_res.first_byte;
  assign last_byte    = out_res.last_byte;

endmodule

[rtl/core/lpd_parse.sv]
// Header parser and payload counter of the length-prefixed deframer.
// Depends on lpd_pkg; one byte per step, result is combinational for the output register.
module lpd_parse
  import lpd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [MAX_LEN_BITS-1:0] cfg_wdata,
  input  logic                    step,
  input  logic [7:0]              step_byte,
  output logic                    res_valid,
  output result_t                 res
);

  localparam logic [31:0] CAP = 32'((33'd1 << COUNT_BITS) - 33'd1);
  localparam logic [2:0]  HDR_TYPE_END = 3'(TYPE_BYTES);
  localparam logic [2:0]  HDR_LAST     = 3'(HEADER_BYTES - 1);

  logic [MAX_LEN_BITS-1:0] max_length;
  logic [2:0]              header_count, header_count_next;
  logic [15:0]             type_hold, type_hold_next;
  logic [23:0]             length_shift, length_shift_next;
  logic [COUNT_BITS-1:0]   bytes_left, bytes_left_next;
  logic                    first_pending, first_pending_next;
  logic                    halted, halted_next;
  logic [31:0]             full_len;

  assign full_len = {length_shift, step_byte};

  always_comb begin
    header_count_next  = header_count;
    type_hold_next     = type_hold;
    length_shift_next  = length_shift;
    bytes_left_next    = bytes_left;
    first_pending_next = first_pending;
    halted_next        = halted;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = KIND_PAYLOAD;
    res.msg_type       = type_hold;
    if (step && !halted) begin
      if (bytes_left != '0) begin
        res_valid          = 1'b1;
        res.payload_byte   = step_byte;
        res.first_byte     = first_pending;
        res.last_byte      = (bytes_left == COUNT_BITS'(1));
        bytes_left_next    = bytes_left - COUNT_BITS'(1);
        first_pending_next = 1'b0;
      end else if (header_count < HDR_TYPE_END) begin
        type_hold_next    = {type_hold[7:0], step_byte};
        header_count_next = header_count + 3'd1;
      end else if (header_count < HDR_LAST) begin
        length_shift_next = {length_shift[15:0], step_byte};
        header_count_next = header_count + 3'd1;
      end else begin
        header_count_next = '0;
        if (full_len > {9'd0, max_length} || full_len > CAP) begin
          // oversize: report once and drop everything until reset
          res_valid   = 1'b1;
          res.kind    = KIND_ERROR;
          halted_next = 1'b1;
        end else if (full_len == 32'd0) begin
          res_valid     = 1'b1;
          res.kind      = KIND_EMPTY;
          res.last_byte = 1'b1;
        end else begin
          bytes_left_next    = full_len[COUNT_BITS-1:0];
          first_pending_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    type_hold    <= type_hold_next;
    length_shift <= length_shift_next;
    if (rst) begin
      max_length    <= LIMIT_RESET;
      header_count  <= '0;
      bytes_left    <= '0;
      first_pending <= 1'b0;
      halted        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      header_count  <= header_count_next;
      bytes_left    <= bytes_left_next;
      first_pending <= first_pending_next;
      halted        <= halted_next;
    end
  end

endmodule

[rtl/core/lpd_out_reg.sv]
// Result register of the length-prefixed deframer, with valid/ready toward the sink.
// Depends on lpd_pkg for the result record.
module lpd_out_reg
  import lpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_res <= load_res;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

endmodule

[rtl/core/lpd_checker.sv]
// Port-level checks for the length-prefixed deframer, bound to the top level.
// Depends on lpd_pkg for the result kind codes.
module lpd_checker
  import lpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] msg_type,
  input logic [7:0]  payload_byte,
  input logic        first_byte,
  input logic        last_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(msg_type)
      && $stable(payload_byte) && $stable(first_byte) && $stable(last_byte))
    else $error("result changed while stalled");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_PAYLOAD || kind == KIND_EMPTY || kind == KIND_ERROR)
    else $error("undefined result kind");

  a_error_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> !first_byte && !last_byte && payload_byte == 8'd0)
    else $error("error item carries marks or data");

  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> !first_byte && last_byte && payload_byte == 8'd0)
    else $error("empty item marks wrong");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_ERROR |=> !out_valid)
    else $error("item after oversize error");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .msg_type     (msg_type),
  .payload_byte (payload_byte),
  .first_byte   (first_byte),
  .last_byte    (last_byte)
);
